FILE: design/assert_macros.svh
// assertion macros shared by the tessellator top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// implication checked at every clock edge outside reset
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`endif

FILE: design/et_pkg.sv
// types, constants and the cordic arctangent table of the ellipse tessellator
// no dependencies
package et_pkg;

  localparam int unsigned MaxSegments = 63;
  localparam int unsigned PhaseBits   = 12;
  localparam int unsigned CoordWidth  = 24;
  localparam int unsigned TrigWidth   = 18;   // signed, 16 fractional bits
  localparam int unsigned TableDepth  = 1 << PhaseBits;

  typedef enum logic [1:0] {
    KIND_CENTER = 2'd0,
    KIND_FAN    = 2'd1,
    KIND_RING   = 2'd2,
    KIND_EMPTY  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_TRIG,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                         mode;
    logic signed [CoordWidth-1:0] center_x;
    logic signed [CoordWidth-1:0] center_y;
    logic [CoordWidth-2:0]        radius_x;
    logic [CoordWidth-2:0]        radius_y;
    logic [CoordWidth-2:0]        stroke_weight;
    logic [5:0]                   segment_count;
  } cmd_t;

  typedef struct packed {
    logic [1:0]                   kind;
    logic signed [CoordWidth-1:0] first_x;
    logic signed [CoordWidth-1:0] first_y;
    logic signed [CoordWidth-1:0] second_x;
    logic signed [CoordWidth-1:0] second_y;
    logic [6:0]                   index_current;
    logic [6:0]                   index_next;
    logic                         last_result;
  } res_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture command, reset segment counter
    logic div_start;  // begin phase divide for current segment
    logic trig_start; // begin cordic
    logic mul_step;   // advance multiply sequence
    logic emit_head;  // emit center or empty result
    logic emit_seg;   // emit segment result
    logic next_seg;   // advance segment index
  } ctrl_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
    logic trig_done;
    logic mul_done;
    logic zero_seg;
    logic ring;
    logic last_seg;
  } stat_t;

  localparam logic [31:0] AtanTurn [16] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C
  };

  localparam logic signed [35:0] CordicGain = 36'sd652032874;

  // floor shift of a signed value (arithmetic shift is floor)
  function automatic logic signed [35:0] asr36(logic signed [35:0] v, logic [3:0] k);
    asr36 = v >>> k;
  endfunction

endpackage

FILE: design/et_ctrl.sv
// controller state machine of the ellipse tessellator
// depends on et_pkg
module et_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_fire_i,
  input  logic           out_free_i,
  input  et_pkg::stat_t  stat_i,
  output et_pkg::ctrl_t  ctrl_o,
  output logic           idle_o
);

  et_pkg::state_e state_q, state_d;

  // the out state with the head flag emits the center or empty result
  logic head_q, head_d;

  // a ring with segments has no head result, go straight to the first divide
  logic skip_head;
  assign skip_head = head_q && stat_i.ring && !stat_i.zero_seg;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      et_pkg::ST_IDLE: if (in_fire_i) state_d = et_pkg::ST_OUT;
      et_pkg::ST_DIV:  if (stat_i.div_done) state_d = et_pkg::ST_TRIG;
      et_pkg::ST_TRIG: if (stat_i.trig_done) state_d = et_pkg::ST_MUL;
      et_pkg::ST_MUL:  if (stat_i.mul_done) state_d = et_pkg::ST_OUT;
      et_pkg::ST_OUT: begin
        if (skip_head) begin
          state_d = et_pkg::ST_DIV;
        end else if (out_free_i) begin
          if (stat_i.last_seg) state_d = et_pkg::ST_IDLE;
          else state_d = et_pkg::ST_DIV;
        end
      end
      default: state_d = et_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    head_d = head_q;
    if (state_q == et_pkg::ST_IDLE && in_fire_i) head_d = 1'b1;
    else if (state_q == et_pkg::ST_OUT && (out_free_i || skip_head)) head_d = 1'b0;
  end

  always_comb begin
    ctrl_o = '0;
    idle_o = 1'b0;
    unique case (state_q)
      et_pkg::ST_IDLE: begin
        idle_o      = 1'b1;
        ctrl_o.load = in_fire_i;
      end
      et_pkg::ST_DIV: ctrl_o.div_start = 1'b0;
      et_pkg::ST_TRIG: ctrl_o.trig_start = 1'b0;
      et_pkg::ST_MUL: ctrl_o.mul_step = 1'b1;
      et_pkg::ST_OUT: begin
        if (out_free_i && !skip_head) begin
          ctrl_o.emit_head = head_q;
          ctrl_o.emit_seg  = !head_q;
          ctrl_o.next_seg  = !head_q;
        end
      end
      default: ctrl_o = '0;
    endcase
    if (state_q == et_pkg::ST_OUT &&
        (skip_head || (out_free_i && !stat_i.last_seg))) ctrl_o.div_start = 1'b1;
    if (state_q == et_pkg::ST_DIV && stat_i.div_done) ctrl_o.trig_start = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= et_pkg::ST_IDLE;
      head_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
    end
  end

endmodule

FILE: design/et_datapath.sv
// datapath: phase divider, cordic, radius multiplier and result assembly
// depends on et_pkg
module et_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  et_pkg::cmd_t  cmd_i,
  input  et_pkg::ctrl_t ctrl_i,
  output et_pkg::stat_t stat_o,
  output et_pkg::res_t  res_o
);

  localparam int unsigned CW = et_pkg::CoordWidth;
  localparam int unsigned PB = et_pkg::PhaseBits;

  et_pkg::cmd_t cmd_q;
  logic [5:0]   n_q;
  logic [5:0]   seg_q;       // segment being produced
  logic         head_q;      // head result not yet sent

  // restoring divider: (seg << PB) / n, one quotient bit a cycle
  logic [PB+5:0] dividend_q;
  logic [6:0]    rem_q;
  logic [PB-1:0] quo_q;
  logic [4:0]    div_cnt_q;
  logic          div_busy_q;
  logic          div_done_q;  // quotient complete

  // cordic
  logic signed [35:0] cx_q, cy_q, cz_q;
  logic [1:0]         quad_q;
  logic [4:0]         cor_cnt_q;
  logic               cor_busy_q;
  logic signed [et_pkg::TrigWidth-1:0] cos_q, sin_q;

  // multiply sequence: four products, one a cycle
  logic [2:0]         mul_cnt_q;
  logic signed [CW+1:0] pos_q [4];

  logic signed [CW+1:0] r2x, r2y, sw_s, rad_sel;
  logic signed [et_pkg::TrigWidth-1:0] trig_sel;
  logic signed [CW-1:0] ctr_sel;
  logic signed [CW+et_pkg::TrigWidth+1:0] prod;
  logic signed [CW+2:0] sum;
  logic signed [CW+1:0] sat_v;

  assign r2x  = $signed({2'b00, cmd_q.radius_x, 1'b0});
  assign r2y  = $signed({2'b00, cmd_q.radius_y, 1'b0});
  assign sw_s = $signed({3'b000, cmd_q.stroke_weight});

  always_comb begin
    case (mul_cnt_q[1:0])
      2'd0: begin
        rad_sel = cmd_q.mode ? r2x - sw_s : r2x; trig_sel = cos_q; ctr_sel = cmd_q.center_x;
      end
      2'd1: begin
        rad_sel = cmd_q.mode ? r2y - sw_s : r2y; trig_sel = sin_q; ctr_sel = cmd_q.center_y;
      end
      2'd2: begin rad_sel = r2x + sw_s; trig_sel = cos_q; ctr_sel = cmd_q.center_x; end
      default: begin rad_sel = r2y + sw_s; trig_sel = sin_q; ctr_sel = cmd_q.center_y; end
    endcase
    prod = rad_sel * trig_sel;
    sum  = $signed({{3{ctr_sel[CW-1]}}, ctr_sel})
         + (CW+3)'((prod + (CW+et_pkg::TrigWidth+2)'(65536)) >>> 17);
    if (sum > (CW+3)'($signed({1'b0, {(CW-1){1'b1}}})))
      sat_v = (CW+2)'($signed({1'b0, {(CW-1){1'b1}}}));
    else if (sum < -(CW+3)'($signed({1'b0, {(CW-1){1'b1}}})) - (CW+3)'(1))
      sat_v = -(CW+2)'($signed({1'b0, {(CW-1){1'b1}}})) - (CW+2)'(1);
    else
      sat_v = (CW+2)'(sum);
  end

  // trial subtract of the divider
  logic [7:0] rem_sh;
  logic [7:0] rem_try;
  assign rem_sh  = {rem_q, dividend_q[PB+5]};
  assign rem_try = rem_sh - {2'b00, n_q};

  logic signed [35:0] dxs, dys;
  assign dxs = et_pkg::asr36(cy_q, cor_cnt_q[3:0]);
  assign dys = et_pkg::asr36(cx_q, cor_cnt_q[3:0]);

  // next rotation step, rounded on the last one
  logic signed [35:0] nx, ny;
  assign nx = (cz_q >= 0) ? cx_q - dxs : cx_q + dxs;
  assign ny = (cz_q >= 0) ? cy_q + dys : cy_q - dys;

  logic signed [35:0] xr, yr;
  assign xr = (nx + 36'sd8192) >>> 14;
  assign yr = (ny + 36'sd8192) >>> 14;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q <= cmd_i;
      n_q   <= cmd_i.segment_count;
    end
    if (ctrl_i.div_start) begin
      dividend_q <= {(head_q ? 6'd0 : seg_q + 6'd1), {PB{1'b0}}};
      rem_q      <= '0;
    end else if (div_busy_q) begin
      dividend_q <= dividend_q << 1;
      if (!rem_try[7]) begin
        rem_q <= rem_try[6:0];
        quo_q <= {quo_q[PB-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[6:0];
        quo_q <= {quo_q[PB-2:0], 1'b0};
      end
    end
    if (ctrl_i.trig_start) begin
      cx_q   <= et_pkg::CordicGain;
      cy_q   <= '0;
      cz_q   <= $signed({6'd0, quo_q[PB-3:0], {(32-PB){1'b0}}});
      quad_q <= quo_q[PB-1:PB-2];
    end else if (cor_busy_q) begin
      cx_q <= nx;
      cy_q <= ny;
      if (cz_q >= 0) begin
        cz_q <= cz_q - $signed({4'd0, et_pkg::AtanTurn[cor_cnt_q[3:0]]});
      end else begin
        cz_q <= cz_q + $signed({4'd0, et_pkg::AtanTurn[cor_cnt_q[3:0]]});
      end
      if (cor_cnt_q == 5'd15) begin
        case (quad_q)
          2'd0: begin cos_q <= xr[17:0];  sin_q <= yr[17:0]; end
          2'd1: begin cos_q <= -yr[17:0]; sin_q <= xr[17:0]; end
          2'd2: begin cos_q <= -xr[17:0]; sin_q <= -yr[17:0]; end
          default: begin cos_q <= yr[17:0]; sin_q <= -xr[17:0]; end
        endcase
      end
    end
    if (ctrl_i.mul_step) pos_q[mul_cnt_q[1:0]] <= sat_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_q      <= '0;
      head_q     <= 1'b0;
      div_busy_q <= 1'b0;
      div_done_q <= 1'b0;
      div_cnt_q  <= '0;
      cor_busy_q <= 1'b0;
      cor_cnt_q  <= '0;
      mul_cnt_q  <= '0;
    end else begin
      if (ctrl_i.load) begin
        seg_q  <= '0;
        head_q <= 1'b1;
      end else begin
        if (ctrl_i.div_start) head_q <= 1'b0;
        if (ctrl_i.next_seg)  seg_q  <= seg_q + 6'd1;
      end
      div_done_q <= div_busy_q && (div_cnt_q == 5'(PB + 5));
      if (ctrl_i.div_start) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= '0;
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q + 5'd1;
        if (div_cnt_q == 5'(PB + 5)) div_busy_q <= 1'b0;
      end
      if (ctrl_i.trig_start) begin
        cor_busy_q <= 1'b1;
        cor_cnt_q  <= '0;
      end else if (cor_busy_q) begin
        cor_cnt_q <= cor_cnt_q + 5'd1;
        if (cor_cnt_q == 5'd15) cor_busy_q <= 1'b0;
      end
      if (ctrl_i.mul_step) mul_cnt_q <= (mul_cnt_q == 3'd3) ? 3'd0 : mul_cnt_q + 3'd1;
    end
  end

  // index of the segment in flight: twice seg_q for a ring, seg_q plus one for a fan
  logic [6:0] ic, inx, n7, i7;
  assign n7 = {1'b0, n_q};
  assign i7 = {1'b0, seg_q};
  always_comb begin
    if (cmd_q.mode) begin
      ic  = {seg_q, 1'b0};
      inx = (i7 + 7'd1 == n7) ? 7'd0 : {seg_q, 1'b0} + 7'd2;
    end else begin
      ic  = i7 + 7'd1;
      inx = (i7 + 7'd1 == n7) ? 7'd1 : i7 + 7'd2;
    end
  end

  always_comb begin
    res_o = '0;
    if (head_q) begin
      if (cmd_q.mode) begin
        res_o.kind = et_pkg::KIND_EMPTY;
      end else begin
        res_o.kind    = et_pkg::KIND_CENTER;
        res_o.first_x = cmd_q.center_x;
        res_o.first_y = cmd_q.center_y;
      end
      res_o.last_result = (n_q == 6'd0);
    end else begin
      res_o.kind          = cmd_q.mode ? et_pkg::KIND_RING : et_pkg::KIND_FAN;
      res_o.first_x       = CW'(pos_q[0]);
      res_o.first_y       = CW'(pos_q[1]);
      res_o.second_x      = cmd_q.mode ? CW'(pos_q[2]) : '0;
      res_o.second_y      = cmd_q.mode ? CW'(pos_q[3]) : '0;
      res_o.index_current = ic;
      res_o.index_next    = inx;
      res_o.last_result   = (i7 + 7'd1 == n7);
    end
  end

  assign stat_o.div_done  = div_done_q;
  assign stat_o.trig_done = cor_busy_q && cor_cnt_q == 5'd15;
  assign stat_o.mul_done  = mul_cnt_q == 3'd3;
  assign stat_o.zero_seg  = (n_q == 6'd0);
  assign stat_o.ring      = cmd_q.mode;
  assign stat_o.last_seg  = res_o.last_result;

endmodule

FILE: design/ellipse_tessellator_core.sv
// ellipse tessellator: one command in, a centre or empty result where needed, then one per segment
// sequence: the centre or empty result comes first, then each segment runs the phase divide,
// the cordic, the multiply sequence and the output; a ring with segments has no head result
// commands: one at a time; output stalls hold the controller in its output state
// reset: asynchronous, active low, clears controller and handshake state
`include "assert_macros.svh"
module ellipse_tessellator_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  et_pkg::cmd_t in_data_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output et_pkg::res_t out_data_o
);

  et_pkg::ctrl_t ctrl;
  et_pkg::stat_t stat;
  et_pkg::res_t  res;
  logic          idle, in_fire, out_free;

  // output register; free when empty or being drained this cycle
  logic          out_valid_q;
  et_pkg::res_t  out_data_q;

  assign in_ready_o = idle && !out_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  et_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_fire_i  (in_fire),
    .out_free_i (out_free),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .idle_o     (idle)
  );

  et_datapath u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i  (in_data_i),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit_head || ctrl.emit_seg) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit_head || ctrl.emit_seg) out_data_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ASSERT_IMPLIES(a_no_accept_busy, clk_i, rst_ni, !idle, !in_ready_o, "accept while busy")
  `ASSERT_ALWAYS(a_one_emit, clk_i, rst_ni, !(ctrl.emit_head && ctrl.emit_seg), "double emit")
  `ASSERT_IMPLIES(a_emit_free, clk_i, rst_ni, ctrl.emit_head || ctrl.emit_seg, out_free, "overwrite")

endmodule
